/* design/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; included by the checker module only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SCF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scf assertion failed");

// next-cycle implication, disabled while reset is high
`define SCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scf assertion failed");

`endif

/* design/scf_pkg.sv */
// shared types, constants and helpers for segment_cross_fraction
// no dependencies; imported by every rtl file of the block
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

   localparam int CoordW   = 16;
   localparam int DiffW    = CoordW + 1;
   localparam int WordW    = 32;
   localparam int FracBits = 16;
   localparam int SatShift = 14;
   // quotient magnitude stays below 2^30 when the divide does not saturate
   localparam int QuoBits  = WordW - FracBits + SatShift;
   localparam int RemW     = WordW + 1;

   localparam logic [WordW-1:0] FRACTION_MISS = '1;
   localparam logic [WordW-1:0] FRACTION_MAX  = {1'b0, {(WordW-1){1'b1}}};
   localparam logic [WordW-1:0] FRACTION_MIN  = {1'b1, {(WordW-1){1'b0}}};

   localparam int CsrIndexW = 8;

   typedef enum logic [CsrIndexW-1:0] {
      REG_RAY_START_X = 8'd0,
      REG_RAY_START_Y = 8'd1,
      REG_RAY_END_X   = 8'd2,
      REG_RAY_END_Y   = 8'd3
   } csr_reg_type;

   typedef struct packed {
      logic signed [CoordW-1:0] start_x;
      logic signed [CoordW-1:0] start_y;
      logic signed [CoordW-1:0] end_x;
      logic signed [CoordW-1:0] end_y;
   } ray_cfg_type;

   typedef struct packed {
      logic signed [CoordW-1:0] second_y;
      logic signed [CoordW-1:0] second_x;
      logic signed [CoordW-1:0] first_y;
      logic signed [CoordW-1:0] first_x;
   } seg_type;

   // one item travelling down the divider cells
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic             sat;
      logic             neg;
      logic [RemW-1:0]  rem;
      logic [WordW-1:0] den;
      logic [QuoBits-1:0] bits;   // dividend bits out the top, quotient bits in the bottom
   } div_lane_type;

   function automatic logic signed [DiffW-1:0] sub_ext(
      input logic signed [CoordW-1:0] x,
      input logic signed [CoordW-1:0] y
   );
      return {x[CoordW-1], x} - {y[CoordW-1], y};
   endfunction

   // product kept modulo 2^32
   function automatic logic [WordW-1:0] mul_wrap(
      input logic signed [DiffW-1:0] x,
      input logic signed [DiffW-1:0] y
   );
      logic signed [2*DiffW-1:0] p;
      p = x * y;
      return p[WordW-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/scf_front.sv */
// front stages: coordinate differences, products, side tests, a and a+b, magnitudes
// depends on scf_pkg; feeds the first divider cell
`timescale 1ns / 1ps
`default_nettype none

module scf_front
   import scf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         in_fire,
   input  wire seg_type      seg,
   input  wire ray_cfg_type  cfg,
   output logic             s1_busy,
   output div_lane_type     lane_out
);

   // stage 1: differences
   logic                     v1_ff, v1_in;
   logic signed [DiffW-1:0]  dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic signed [DiffW-1:0]  rx_ff, ry_ff, nx_ff, ny_ff, ex_ff, ey_ff;
   // stage 2: products
   logic                     v2_ff;
   logic [WordW-1:0]         s2l_ff, s2r_ff, s1l_ff, s1r_ff;
   logic [WordW-1:0]         pa0_ff, pa1_ff, pb0_ff, pb1_ff;
   // stage 3: side tests and sums
   logic                     v3_ff, hit3_ff;
   logic [WordW-1:0]         a3_ff, eb3_ff;
   // stage 4: divisor
   logic                     v4_ff, hit4_ff;
   logic [WordW-1:0]         a4_ff, den4_ff;
   // stage 5: magnitudes
   logic                     v5_ff, hit5_ff, neg5_ff;
   logic [WordW-1:0]         mag_a_ff, mag_den_ff;
   // stage 6: divider setup
   div_lane_type             lane_ff, lane_in;

   assign v1_in   = advance ? in_fire : (v1_ff | in_fire);
   assign s1_busy = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      if (in_fire) begin
         dx1_ff <= sub_ext(seg.first_x, cfg.start_x);
         dy1_ff <= sub_ext(seg.first_y, cfg.start_y);
         dx2_ff <= sub_ext(seg.second_x, cfg.start_x);
         dy2_ff <= sub_ext(seg.second_y, cfg.start_y);
         rx_ff  <= sub_ext(cfg.end_x, cfg.start_x);
         ry_ff  <= sub_ext(cfg.end_y, cfg.start_y);
         nx_ff  <= sub_ext(seg.first_y, seg.second_y);
         ny_ff  <= sub_ext(seg.second_x, seg.first_x);
         ex_ff  <= sub_ext(cfg.end_x, seg.first_x);
         ey_ff  <= sub_ext(cfg.end_y, seg.first_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (advance) begin
         s2l_ff <= mul_wrap(ry_ff, dx2_ff);
         s2r_ff <= mul_wrap(dy2_ff, rx_ff);
         s1l_ff <= mul_wrap(ry_ff, dx1_ff);
         s1r_ff <= mul_wrap(dy1_ff, rx_ff);
         pa0_ff <= mul_wrap(nx_ff, dx1_ff);
         pa1_ff <= mul_wrap(ny_ff, dy1_ff);
         pb0_ff <= mul_wrap(nx_ff, ex_ff);
         pb1_ff <= mul_wrap(ny_ff, ey_ff);

         // hit when the two strict side tests disagree
         hit3_ff <= ($signed(s2l_ff) < $signed(s2r_ff)) != ($signed(s1l_ff) < $signed(s1r_ff));
         a3_ff   <= pa0_ff + pa1_ff;
         eb3_ff  <= pb0_ff + pb1_ff;

         hit4_ff <= hit3_ff;
         a4_ff   <= a3_ff;
         den4_ff <= a3_ff + eb3_ff;

         hit5_ff    <= hit4_ff;
         neg5_ff    <= a4_ff[WordW-1] ^ den4_ff[WordW-1];
         mag_a_ff   <= a4_ff[WordW-1] ? (~a4_ff + 1'b1) : a4_ff;
         mag_den_ff <= den4_ff[WordW-1] ? (~den4_ff + 1'b1) : den4_ff;
      end
   end

   always_comb begin
      lane_in.valid = v5_ff;
      lane_in.hit   = hit5_ff;
      lane_in.neg   = neg5_ff;
      lane_in.sat   = (mag_a_ff >> SatShift) >= mag_den_ff;
      // dividend is |a| << 16; the part above the quotient bits seeds the remainder
      lane_in.rem   = {{(RemW-WordW+SatShift){1'b0}}, mag_a_ff[WordW-1:SatShift]};
      lane_in.den   = mag_den_ff;
      lane_in.bits  = {mag_a_ff[SatShift-1:0], {FracBits{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

/* design/scf_div_cell.sv */
// one restoring-divide cell: one quotient bit per item, handed to the next cell
// depends on scf_pkg
`timescale 1ns / 1ps
`default_nettype none

module scf_div_cell
   import scf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire div_lane_type  prev_lane,
   output div_lane_type      next_lane
);

   div_lane_type    lane_ff, lane_in;
   logic [RemW-1:0] rem_sh;
   logic            take;

   always_comb begin
      rem_sh  = {prev_lane.rem[RemW-2:0], prev_lane.bits[QuoBits-1]};
      take    = rem_sh >= {1'b0, prev_lane.den};
      lane_in = prev_lane;
      lane_in.rem  = take ? (rem_sh - {1'b0, prev_lane.den}) : rem_sh;
      lane_in.bits = {prev_lane.bits[QuoBits-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign next_lane = lane_ff;

endmodule

`default_nettype wire

/* design/segment_cross_fraction.sv */
// top level of segment_cross_fraction: ray registers, front stages, divider cells, result beat
// depends on scf_pkg, scf_front and scf_div_cell
//
//   channel   dir   handshake                 payload
//   req       in    req_tvalid / req_tready   req_tdata: first_x, first_y, second_x, second_y
//   rsp       out   rsp_tvalid / rsp_tready   rsp_tdata: fraction; rsp_tuser: hit
//   csr       in    csr_valid / csr_ready     csr_index, csr_wdata (ray end points)
//
// one segment beat is taken every cycle while the result side does not stall; the path runs
// through six front stages, a row of 30 divider cells (one quotient bit each), and the result register
// reset is synchronous and clears the ray registers and all valid bits
// a result that is not taken holds the whole row; the first stage still fills if empty
// csr writes are taken every cycle and must only come while the block is idle
`timescale 1ns / 1ps
`default_nettype none

module segment_cross_fraction
   import scf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // segment beats
   input  wire logic                  req_tvalid,
   output logic                      req_tready,
   input  wire logic [4*CoordW-1:0]   req_tdata,   // first_x, first_y, second_x, second_y
   // result beats
   output logic                      rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [WordW-1:0]          rsp_tdata,   // fraction
   output logic [0:0]                rsp_tuser,   // hit
   // ray registers
   input  wire logic                  csr_valid,
   output logic                      csr_ready,
   input  wire logic [CsrIndexW-1:0]  csr_index,
   input  wire logic [CoordW-1:0]     csr_wdata
);

   ray_cfg_type      cfg_ff;
   logic             advance;
   logic             in_fire;
   logic             s1_busy;
   seg_type          seg;
   div_lane_type     lanes [0:QuoBits];
   div_lane_type     last;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff;
   logic [WordW-1:0] rsp_frac_ff, frac_in;
   logic [WordW-1:0] quo_ext;

   // ray registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_RAY_START_X: cfg_ff.start_x <= csr_wdata;
            REG_RAY_START_Y: cfg_ff.start_y <= csr_wdata;
            REG_RAY_END_X:   cfg_ff.end_x   <= csr_wdata;
            REG_RAY_END_Y:   cfg_ff.end_y   <= csr_wdata;
            default: ;   // unknown index, write dropped
         endcase
      end
   end

   // the whole row moves when the result register is free or being emptied
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = advance | ~s1_busy;
   assign in_fire    = req_tvalid & req_tready;
   assign seg        = seg_type'(req_tdata);

   scf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_fire  (in_fire),
      .seg      (seg),
      .cfg      (cfg_ff),
      .s1_busy  (s1_busy),
      .lane_out (lanes[0])
   );

   // one cell per quotient bit, most significant first
   for (genvar i = 0; i < QuoBits; i++) begin : g_cell
      scf_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prev_lane (lanes[i]),
         .next_lane (lanes[i+1])
      );
   end

   assign last    = lanes[QuoBits];
   assign quo_ext = {{(WordW-QuoBits){1'b0}}, last.bits};

   // miss, saturated, or signed quotient truncated toward zero
   always_comb begin
      if (!last.hit) begin
         frac_in = FRACTION_MISS;
      end else if (last.sat) begin
         frac_in = last.neg ? FRACTION_MIN : FRACTION_MAX;
      end else begin
         frac_in = last.neg ? (~quo_ext + 1'b1) : quo_ext;
      end
   end

   assign rsp_valid_in = advance ? last.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_hit_ff  <= last.hit;
         rsp_frac_ff <= frac_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_frac_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

endmodule

`default_nettype wire

/* design/scf_checker.sv */
// port-level checks for segment_cross_fraction, bound to the top level
// depends on scf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scf_checker
   import scf_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [WordW-1:0] rsp_tdata,
   input wire logic [0:0]       rsp_tuser,
   input wire logic             csr_ready
);

   // a miss always carries the all-ones fraction
   `SCF_ASSERT_NOW(a_miss_fraction, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == FRACTION_MISS)

   // an empty result register never blocks the segment side
   `SCF_ASSERT_NOW(a_ready_when_out_free, clock, reset, !rsp_tvalid, req_tready)

   // the ray registers take a write in every cycle
   `SCF_ASSERT_NOW(a_csr_always_ready, clock, reset, 1'b1, csr_ready)

   // a stalled result beat holds
   `SCF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind segment_cross_fraction scf_checker u_scf_checker (.*);

`default_nettype wire
